// ----- hw/rtl/grid_local_minimum_detect_defines.svh -----
// Assertion macros shared by the grid low point detector.
`ifndef GRID_LOCAL_MINIMUM_DETECT_DEFINES_SVH
`define GRID_LOCAL_MINIMUM_DETECT_DEFINES_SVH

// Checks a consequence in the same cycle as its cause.
`define GLMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its cause.
`define GLMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/glmd_pkg.sv -----
// Shared types and constants of the grid low point detector.
package glmd_pkg;

    // Default grid limits.
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    // Field widths.
    localparam int HEIGHT_W   = 4;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int RISK_W     = 32;
    localparam int COLS_CFG_W = 11;
    localparam int ROWS_CFG_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;
    localparam int M_PAD_W   = M_TDATA_W - RISK_W - HEIGHT_W - COL_W - ROW_W;

    // Register reset values.
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 13'd1;

    // Results per cell, result queue size and window length.
    localparam int RESULTS_MAX = 3;
    localparam int OQ_DEPTH    = 8;
    localparam int OQ_AW       = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);
    localparam int WIN_CELLS   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLUMNS = 1'b0,
        CFG_GRID_ROWS    = 1'b1
    } t_cfg_index;

    // One line store entry: rows r-2 and r-1 of a column.
    typedef struct packed {
        logic [HEIGHT_W-1:0] up;
        logic [HEIGHT_W-1:0] mid;
    } t_entry;

    // One window column: rows r-1 and r of a column.
    typedef struct packed {
        logic [HEIGHT_W-1:0] mid;
        logic [HEIGHT_W-1:0] cur;
    } t_column;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [HEIGHT_W-1:0] value;
        logic                low;
        logic [RISK_W-1:0]   risk;
        logic                last;
    } t_result;

    typedef struct packed {
        logic    vld;
        t_result res;
    } t_slot;

endpackage

// ----- hw/rtl/glmd_ram.sv -----
// Generic RAM: one write port, two read ports with registered data.
module glmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [WIDTH-1:0]           o_rdata_a,
    output logic [WIDTH-1:0]           o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Reads return the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hw/rtl/glmd_cell.sv -----
// Window cell: holds one grid column and passes it to the next cell on a shift.
module glmd_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  glmd_pkg::t_column i_col,
    output glmd_pkg::t_column o_col
);

    import glmd_pkg::*;

    t_column r_col;

    // Each processed cell moves the window one column to the right.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// ----- hw/rtl/glmd_outq.sv -----
// Result queue: takes up to three results a cycle in order, hands out one while the reader is ready.
module glmd_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  glmd_pkg::t_slot            i_slot [glmd_pkg::RESULTS_MAX],
    output logic                       o_valid,
    input  logic                       i_ready,
    output glmd_pkg::t_result          o_head,
    output logic [glmd_pkg::OQ_CNT_W-1:0] o_count
);

    import glmd_pkg::*;

    t_result            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wp;
    logic [OQ_AW-1:0]   r_rp;
    logic [OQ_CNT_W-1:0] r_count;
    logic [OQ_AW-1:0]   off [RESULTS_MAX];
    logic [OQ_AW-1:0]   widx [RESULTS_MAX];
    logic [OQ_CNT_W-1:0] n_push;
    logic               pop;

    // Valid slots are packed together behind the write pointer.
    always_comb begin
        off[0] = '0;
        for (int i = 1; i < RESULTS_MAX; i++) begin
            off[i] = off[i-1] + OQ_AW'(i_slot[i-1].vld);
        end
        n_push = '0;
        for (int i = 0; i < RESULTS_MAX; i++) begin
            widx[i] = r_wp + off[i];
            n_push  = n_push + OQ_CNT_W'(i_slot[i].vld);
        end
    end

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + OQ_AW'(n_push);
            r_rp    <= r_rp + OQ_AW'(pop);
            r_count <= r_count + n_push - OQ_CNT_W'(pop);
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RESULTS_MAX; i++) begin
            if (i_slot[i].vld) begin
                r_mem[widx[i]] <= i_slot[i].res;
            end
        end
    end

endmodule

// ----- hw/rtl/grid_local_minimum_detect.sv -----
// Top level of the streaming grid low point detector.
//
// Channel  Dir  Handshake                 Payload
// s        in   i_s_tvalid / o_s_tready   i_s_tdata: cell_height
// m        out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser: low flag, o_m_tlast: frame end
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One cell request is taken per clock while o_s_tready is high. A cell is decided in
// the cycle after the request that completes its neighborhood (registered line store
// read), and its result is queued. The last row yields up to three results per cell,
// more than the one-per-clock output drains; the eight-entry result queue sets
// o_s_tready. Synchronous active-low reset clears counters, sum, queue and sets the grid
// to 1024 x 1; the line stores are not cleared. An output stall fills the queue first.
`include "grid_local_minimum_detect_defines.svh"

module grid_local_minimum_detect #(
    parameter int MAX_COLS = glmd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = glmd_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // [3:0] cell_height, [7:4] zero
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [glmd_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [11:0] cell_row, [21:12] cell_col, [25:22] cell_value, [57:26] risk_total, [63:58] zero
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [glmd_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] is_low_point
    output logic                           o_m_tuser,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [glmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [glmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import glmd_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RAM_W = $bits(t_entry);

    // Configuration.
    logic [COLS_CFG_W-1:0] r_cfg_cols;
    logic [ROWS_CFG_W-1:0] r_cfg_rows;

    // Request stage.
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    logic [31:0]    cols_eff;
    logic [31:0]    rows_eff;
    logic           a_last_col;
    logic           a_last_row;
    logic           s_accept;
    logic           n_fwd_a;
    logic           n_fwd_b;

    // Decision stage.
    logic                r_b_vld;
    logic [HEIGHT_W-1:0] r_b_h;
    logic [RW-1:0]       r_b_row;
    logic [CW-1:0]       r_b_col;
    logic                r_b_lc;
    logic                r_b_lr;
    logic                r_fwd_a;
    logic                r_fwd_b;
    t_entry              r_fw_entry;
    logic [RISK_W-1:0]   r_risk;

    logic [RAM_W-1:0]    ram_a;
    logic [RAM_W-1:0]    ram_b;
    t_entry              ent_a;
    t_entry              ent_b;
    t_entry              wentry;
    logic [HEIGHT_W-1:0] up_c;
    logic [HEIGHT_W-1:0] mid_c;
    logic [HEIGHT_W-1:0] mid_c1;
    logic [HEIGHT_W-1:0] lm;
    logic [HEIGHT_W-1:0] lcur;
    logic [HEIGHT_W-1:0] sl;
    logic                b_r_ge1;
    logic                b_r_ge2;
    logic                b_c_ge1;
    logic                b_c_ge2;
    logic                b_frame_end;
    logic [5:0]          add [RESULTS_MAX];
    logic [5:0]          pre [RESULTS_MAX];
    t_slot               slot [RESULTS_MAX];

    t_column             win_in [WIN_CELLS];
    t_column             win [WIN_CELLS];

    t_result             head;
    logic [OQ_CNT_W-1:0] oq_count;

    // Saturating add of a small prefix sum onto the running total.
    function automatic logic [RISK_W-1:0] sat_add(input logic [RISK_W-1:0] acc,
                                                  input logic [5:0] inc);
        logic [RISK_W:0] sum;
        sum = {1'b0, acc} + (RISK_W + 1)'(inc);
        return sum[RISK_W] ? {RISK_W{1'b1}} : sum[RISK_W-1:0];
    endfunction

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLS_RESET;
            r_cfg_rows <= ROWS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_GRID_COLUMNS: r_cfg_cols <= i_cfg_data[COLS_CFG_W-1:0];
                CFG_GRID_ROWS:    r_cfg_rows <= i_cfg_data[ROWS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective grid size: zero acts as one, large values clip to the maximum.
    always_comb begin
        if (r_cfg_cols == '0) begin
            cols_eff = 32'd1;
        end else if (32'(r_cfg_cols) > 32'(MAX_COLS)) begin
            cols_eff = 32'(MAX_COLS);
        end else begin
            cols_eff = 32'(r_cfg_cols);
        end
        if (r_cfg_rows == '0) begin
            rows_eff = 32'd1;
        end else if (32'(r_cfg_rows) > 32'(MAX_ROWS)) begin
            rows_eff = 32'(MAX_ROWS);
        end else begin
            rows_eff = 32'(r_cfg_rows);
        end
    end

    assign a_last_col = (32'(r_col) + 32'd1) >= cols_eff;
    assign a_last_row = (32'(r_row) + 32'd1) >= rows_eff;

    // Room for the results of the cell in flight and of the new one.
    assign o_s_tready = (32'(oq_count) + (r_b_vld ? 32'(2 * RESULTS_MAX) : 32'(RESULTS_MAX)))
                        <= 32'(OQ_DEPTH);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Raster position of the next cell.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (a_last_col) begin
            n_col = '0;
            n_row = a_last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    // A line store write lands in the same cycle as the next read; forward it.
    assign n_fwd_a = s_accept && r_b_vld && (r_col == r_b_col);
    assign n_fwd_b = s_accept && r_b_vld && ((r_col + 1'b1) == r_b_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_b_vld <= 1'b0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            r_b_vld <= s_accept;
            r_fwd_a <= n_fwd_a;
            r_fwd_b <= n_fwd_b;
            if (s_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_entry <= wentry;
        if (s_accept) begin
            r_b_h   <= i_s_tdata[HEIGHT_W-1:0];
            r_b_row <= r_row;
            r_b_col <= r_col;
            r_b_lc  <= a_last_col;
            r_b_lr  <= a_last_row;
        end
    end

    // Line stores: rows r-2 and r-1 side by side, read at columns c and c+1.
    glmd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (r_b_vld),
        .i_waddr   (r_b_col),
        .i_wdata   (wentry),
        .i_raddr_a (r_col),
        .i_raddr_b (r_col + 1'b1),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    assign ent_a  = r_fwd_a ? r_fw_entry : t_entry'(ram_a);
    assign ent_b  = r_fwd_b ? r_fw_entry : t_entry'(ram_b);
    assign up_c   = ent_a.up;
    assign mid_c  = ent_a.mid;
    assign mid_c1 = ent_b.mid;
    assign wentry = '{up: mid_c, mid: r_b_h};

    // Window of the two columns left of the current one.
    assign win_in[0] = '{mid: mid_c, cur: r_b_h};

    for (genvar k = 0; k < WIN_CELLS; k++) begin : g_win
        if (k > 0) begin : g_link
            assign win_in[k] = win[k-1];
        end
        glmd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_b_vld),
            .i_col   (win_in[k]),
            .o_col   (win[k])
        );
    end

    assign lm   = win[0].mid;
    assign lcur = win[0].cur;
    assign sl   = win[1].cur;

    assign b_r_ge1     = (r_b_row != '0);
    assign b_r_ge2     = 32'(r_b_row) >= 32'd2;
    assign b_c_ge1     = (r_b_col != '0);
    assign b_c_ge2     = 32'(r_b_col) >= 32'd2;
    assign b_frame_end = r_b_lr && r_b_lc;

    // Decide up to three cells: the one above, on the last row the one to the
    // left, and at the end of the frame the current one.
    always_comb begin
        slot[0].vld       = r_b_vld && b_r_ge1;
        slot[0].res.row   = ROW_W'(r_b_row - 1'b1);
        slot[0].res.col   = COL_W'(r_b_col);
        slot[0].res.value = mid_c;
        slot[0].res.low   = !(b_r_ge2 && (up_c <= mid_c)) && !(b_c_ge1 && (lm <= mid_c))
                            && !(!r_b_lc && (mid_c1 <= mid_c)) && !(r_b_h <= mid_c);
        slot[0].res.last  = 1'b0;

        slot[1].vld       = r_b_vld && r_b_lr && b_c_ge1;
        slot[1].res.row   = ROW_W'(r_b_row);
        slot[1].res.col   = COL_W'(r_b_col - 1'b1);
        slot[1].res.value = lcur;
        slot[1].res.low   = !(b_c_ge2 && (sl <= lcur)) && !(b_r_ge1 && (lm <= lcur))
                            && !(r_b_h <= lcur);
        slot[1].res.last  = 1'b0;

        slot[2].vld       = r_b_vld && b_frame_end;
        slot[2].res.row   = ROW_W'(r_b_row);
        slot[2].res.col   = COL_W'(r_b_col);
        slot[2].res.value = r_b_h;
        slot[2].res.low   = !(b_c_ge1 && (lcur <= r_b_h)) && !(b_r_ge1 && (mid_c <= r_b_h));
        slot[2].res.last  = 1'b1;

        // Each result carries the total including its own contribution.
        for (int i = 0; i < RESULTS_MAX; i++) begin
            add[i] = (slot[i].vld && slot[i].res.low) ? 6'(slot[i].res.value) + 6'd1 : 6'd0;
        end
        pre[0] = add[0];
        for (int i = 1; i < RESULTS_MAX; i++) begin
            pre[i] = pre[i-1] + add[i];
        end
        for (int i = 0; i < RESULTS_MAX; i++) begin
            slot[i].res.risk = sat_add(r_risk, pre[i]);
        end
    end

    // Running total, cleared after the last cell of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_risk <= '0;
        end else if (r_b_vld) begin
            r_risk <= b_frame_end ? '0 : slot[RESULTS_MAX-1].res.risk;
        end
    end

    glmd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (slot),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_head  (head),
        .o_count (oq_count)
    );

    assign o_m_tdata = {{M_PAD_W{1'b0}}, head.risk, head.value, head.col, head.row};
    assign o_m_tuser = head.low;
    assign o_m_tlast = head.last;

    // Checks.
    `GLMD_ASSERT_NEXT(a_risk_clears, r_b_vld && b_frame_end, r_risk == '0, "sum not cleared")
    `GLMD_ASSERT_NEXT(a_result_queued, r_b_vld && b_r_ge1, o_m_tvalid, "decided cell lost")
    `GLMD_ASSERT_NOW(a_fwd_with_item, r_fwd_a || r_fwd_b, r_b_vld, "forward without cell")

endmodule
